FILE: rtl/core/stepper_feed_motion_state_machine_defines.svh
// assertion macros for the stepper feed motion supervisor
`ifndef STEPPER_FEED_MOTION_STATE_MACHINE_DEFINES_SVH
`define STEPPER_FEED_MOTION_STATE_MACHINE_DEFINES_SVH

// same-cycle implication on the checker clock
`define STFM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the checker clock
`define STFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/stfm_pkg.sv
// types, codes and helpers shared by the motion supervisor files
package stfm_pkg;

    localparam int SPEED_BITS = 20;
    localparam int SPEED_W    = 20;

    localparam logic [SPEED_W-1:0] SPEED_LIM =
        (SPEED_BITS >= SPEED_W) ? {SPEED_W{1'b1}}
                                : SPEED_W'((64'd1 << SPEED_BITS) - 64'd1);

    localparam logic [2:0] FN_TICK  = 3'd0;
    localparam logic [2:0] FN_STOP  = 3'd1;
    localparam logic [2:0] FN_SPEED = 3'd2;
    localparam logic [2:0] FN_START = 3'd3;
    localparam logic [2:0] FN_ACCEL = 3'd4;

    localparam logic [2:0] MS_STOPPED = 3'd0;
    localparam logic [2:0] MS_ACCEL   = 3'd1;
    localparam logic [2:0] MS_COAST   = 3'd2;
    localparam logic [2:0] MS_DECEL   = 3'd3;
    localparam logic [2:0] MS_CHDIR   = 3'd4;

    typedef enum logic [4:0] {
        ST_STOPPED = 5'b00001,
        ST_ACCEL   = 5'b00010,
        ST_COAST   = 5'b00100,
        ST_DECEL   = 5'b01000,
        ST_CHDIR   = 5'b10000
    } t_state;

    typedef struct packed {
        logic [2:0]         func;
        logic               req_direction;
        logic [SPEED_W-1:0] req_speed;
        logic [SPEED_W-1:0] cur_speed;
        logic               cur_direction;
        logic [SPEED_W-1:0] goal_speed;
        logic               goal_direction;
        logic               is_running;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         motion_state;
        logic               set_speed_strobe;
        logic [SPEED_W-1:0] set_speed_value;
        logic               set_dir_strobe;
        logic               set_dir_value;
        logic               stop_strobe;
        logic               start_strobe;
    } t_result;

    function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPEED_W-1:0] v);
        sat_speed = (v > SPEED_LIM) ? SPEED_LIM : v;
    endfunction

    function automatic logic [2:0] state_code(input t_state s);
        logic [2:0] c;
        case (s)
            ST_STOPPED: c = MS_STOPPED;
            ST_ACCEL:   c = MS_ACCEL;
            ST_COAST:   c = MS_COAST;
            ST_DECEL:   c = MS_DECEL;
            ST_CHDIR:   c = MS_CHDIR;
            default:    c = MS_STOPPED;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/core/stfm_in_stage.sv
// input register and upstream handshake
module stfm_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  stfm_pkg::t_in_item i_item,
    input  logic              i_out_busy,
    output logic              o_fire,
    output stfm_pkg::t_in_item o_item
);
    import stfm_pkg::*;

    logic     r_valid, n_valid;
    t_in_item r_item;
    logic     w_load;

    assign o_fire  = r_valid && !i_out_busy;
    assign o_stall = r_valid && i_out_busy;
    assign w_load  = i_valid && !o_stall;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (o_fire) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: rtl/core/stfm_fsm.sv
// motion state register and event decode
module stfm_fsm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  stfm_pkg::t_in_item i_item,
    output stfm_pkg::t_result  o_result
);
    import stfm_pkg::*;

    t_state r_state, n_state;
    logic [SPEED_W-1:0] w_rspd, w_cspd, w_gspd;
    logic w_sp, w_dr, w_stp, w_strt, w_idle, w_dchg;

    assign w_rspd = sat_speed(i_item.req_speed);
    assign w_cspd = sat_speed(i_item.cur_speed);
    assign w_gspd = sat_speed(i_item.goal_speed);
    assign w_dchg = i_item.cur_direction != i_item.req_direction;

    always_comb begin
        n_state = r_state;
        w_sp    = 1'b0;
        w_dr    = 1'b0;
        w_stp   = 1'b0;
        w_strt  = 1'b0;
        w_idle  = 1'b0;
        case (i_item.func)
            FN_TICK: begin
                case (r_state)
                    ST_CHDIR: begin
                        if (i_item.cur_direction == i_item.goal_direction &&
                            w_cspd != '0) begin
                            if (w_cspd < w_gspd) begin
                                n_state = ST_ACCEL;
                            end else if (w_cspd == w_gspd) begin
                                n_state = ST_COAST;
                            end
                        end
                    end
                    ST_ACCEL: begin
                        if (w_cspd == w_gspd) n_state = ST_COAST;
                    end
                    ST_DECEL: begin
                        if (w_cspd == w_gspd) begin
                            n_state = (w_cspd == '0) ? ST_STOPPED : ST_COAST;
                        end
                    end
                    default: ;
                endcase
            end
            FN_STOP: begin
                w_stp = 1'b1;
                case (r_state)
                    ST_CHDIR, ST_ACCEL, ST_COAST: n_state = ST_DECEL;
                    default: ;
                endcase
            end
            FN_SPEED: begin
                case (r_state)
                    ST_CHDIR, ST_ACCEL: begin
                        if (w_rspd < w_cspd) n_state = ST_DECEL;
                        w_sp = w_rspd != w_cspd;
                    end
                    ST_COAST: begin
                        if (w_rspd < w_cspd) begin
                            w_sp    = 1'b1;
                            n_state = ST_DECEL;
                        end else if (w_rspd > w_cspd) begin
                            w_sp    = 1'b1;
                            n_state = ST_ACCEL;
                        end
                    end
                    ST_DECEL: begin
                        w_sp = 1'b1;
                        if (w_rspd > w_cspd) begin
                            n_state = ST_ACCEL;
                        end else if (w_rspd == w_cspd) begin
                            n_state = ST_COAST;
                        end
                    end
                    ST_STOPPED: begin
                        w_sp    = 1'b1;
                        n_state = ST_ACCEL;
                    end
                    default: ;
                endcase
            end
            FN_START: begin
                case (r_state)
                    ST_ACCEL, ST_DECEL: begin
                        if (w_dchg) begin
                            n_state = ST_CHDIR;
                            w_dr    = 1'b1;
                        end else if (w_rspd > w_cspd) begin
                            n_state = ST_ACCEL;
                        end else if (w_rspd < w_cspd) begin
                            if (r_state == ST_ACCEL) n_state = ST_DECEL;
                        end else begin
                            n_state = ST_COAST;
                        end
                        w_sp = w_rspd != w_cspd;
                    end
                    ST_COAST: begin
                        if (w_dchg) begin
                            n_state = ST_CHDIR;
                            w_dr    = 1'b1;
                        end else if (w_rspd > w_cspd) begin
                            w_sp    = 1'b1;
                            n_state = ST_ACCEL;
                        end else if (w_rspd < w_cspd) begin
                            w_sp    = 1'b1;
                            n_state = ST_DECEL;
                        end else begin
                            w_idle = 1'b1;
                        end
                    end
                    ST_STOPPED: begin
                        w_dr = w_dchg;
                        if (w_rspd != '0) begin
                            n_state = ST_ACCEL;
                            w_sp    = 1'b1;
                        end
                    end
                    ST_CHDIR: begin
                        if (w_dchg) begin
                            w_dr = 1'b1;
                        end else if (w_rspd > w_cspd) begin
                            n_state = ST_ACCEL;
                        end else if (w_rspd == w_cspd) begin
                            n_state = ST_COAST;
                        end
                        w_sp = w_rspd != w_cspd;
                    end
                    default: ;
                endcase
                w_strt = !w_idle && !i_item.is_running;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_STOPPED;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_result.motion_state     = state_code(n_state);
        o_result.set_speed_strobe = w_sp;
        o_result.set_speed_value  = w_sp ? w_rspd : '0;
        o_result.set_dir_strobe   = w_dr;
        o_result.set_dir_value    = w_dr & i_item.req_direction;
        o_result.stop_strobe      = w_stp;
        o_result.start_strobe     = w_strt;
    end

endmodule

FILE: rtl/core/stfm_out_stage.sv
// result register and downstream handshake
module stfm_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  stfm_pkg::t_result i_result,
    input  logic              i_stall,
    output logic              o_valid,
    output logic              o_busy,
    output stfm_pkg::t_result o_result
);
    import stfm_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;

    assign o_busy   = r_valid && i_stall;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_fire) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: rtl/core/stepper_feed_motion_state_machine.sv
// top level of the stepper feed motion supervisor
//
//  channel   signals                 request
//  -------   ---------------------   ---------------------------------
//  event in  i_valid / o_stall       one event with ramp engine status
//  result    o_valid / i_stall       new state and command strobes
//
// every event gives one result, passing the input register and then the result register
// one event per cycle sustained while the result is not stalled: input register, decode, result register
// the state register updates as an event moves into the result register
// a stalled result holds and the input register still takes one more event
// synchronous reset returns the machine to stopped and empties both registers
module stepper_feed_motion_state_machine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_func,
    input  logic        i_req_direction,
    input  logic [19:0] i_req_speed,
    input  logic [19:0] i_cur_speed,
    input  logic        i_cur_direction,
    input  logic [19:0] i_goal_speed,
    input  logic        i_goal_direction,
    input  logic        i_is_running,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_motion_state,
    output logic        o_set_speed_strobe,
    output logic [19:0] o_set_speed_value,
    output logic        o_set_dir_strobe,
    output logic        o_set_dir_value,
    output logic        o_stop_strobe,
    output logic        o_start_strobe
);
    import stfm_pkg::*;

    t_in_item w_in_item, w_stage_item;
    t_result  w_next_result, w_out_result;
    logic     w_fire, w_out_busy;

    always_comb begin
        w_in_item.func           = i_func;
        w_in_item.req_direction  = i_req_direction;
        w_in_item.req_speed      = i_req_speed;
        w_in_item.cur_speed      = i_cur_speed;
        w_in_item.cur_direction  = i_cur_direction;
        w_in_item.goal_speed     = i_goal_speed;
        w_in_item.goal_direction = i_goal_direction;
        w_in_item.is_running     = i_is_running;
    end

    stfm_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (w_in_item),
        .i_out_busy (w_out_busy),
        .o_fire     (w_fire),
        .o_item     (w_stage_item)
    );

    stfm_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (w_stage_item),
        .o_result (w_next_result)
    );

    stfm_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_result (w_next_result),
        .i_stall  (i_stall),
        .o_valid  (o_valid),
        .o_busy   (w_out_busy),
        .o_result (w_out_result)
    );

    assign o_motion_state     = w_out_result.motion_state;
    assign o_set_speed_strobe = w_out_result.set_speed_strobe;
    assign o_set_speed_value  = w_out_result.set_speed_value;
    assign o_set_dir_strobe   = w_out_result.set_dir_strobe;
    assign o_set_dir_value    = w_out_result.set_dir_value;
    assign o_stop_strobe      = w_out_result.stop_strobe;
    assign o_start_strobe     = w_out_result.start_strobe;

endmodule

FILE: rtl/core/stfm_checker.sv
// port-level checks for the motion supervisor and their bind
`include "stepper_feed_motion_state_machine_defines.svh"

module stfm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_motion_state,
    input logic        o_set_speed_strobe,
    input logic [19:0] o_set_speed_value,
    input logic        o_set_dir_strobe,
    input logic        o_set_dir_value,
    input logic        o_stop_strobe,
    input logic        o_start_strobe
);
    import stfm_pkg::*;

    logic        w_stalled;
    logic [22:0] w_held;
    logic        w_no_speed, w_speed_zero;
    logic        w_no_dir;
    logic        w_stop_seen, w_stop_ok;

    assign w_stalled    = o_valid && i_stall;
    assign w_held       = {o_motion_state, o_set_speed_value};
    assign w_no_speed   = o_valid && !o_set_speed_strobe;
    assign w_speed_zero = o_set_speed_value == '0;
    assign w_no_dir     = o_valid && !o_set_dir_strobe;
    assign w_stop_seen  = o_valid && o_stop_strobe;
    assign w_stop_ok    = !o_set_speed_strobe && !o_set_dir_strobe && !o_start_strobe &&
                          (o_motion_state == MS_DECEL || o_motion_state == MS_STOPPED);

    `STFM_ASSERT_NEXT(a_stall_hold, w_stalled, o_valid && $stable(w_held), "stalled result changed")
    `STFM_ASSERT_NOW(a_speed_zero, w_no_speed, w_speed_zero, "speed value without strobe")
    `STFM_ASSERT_NOW(a_dir_zero, w_no_dir, !o_set_dir_value, "direction value without strobe")
    `STFM_ASSERT_NOW(a_stop_only, w_stop_seen, w_stop_ok, "bad stop request")

endmodule

bind stepper_feed_motion_state_machine stfm_checker u_stfm_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_motion_state     (o_motion_state),
    .o_set_speed_strobe (o_set_speed_strobe),
    .o_set_speed_value  (o_set_speed_value),
    .o_set_dir_strobe   (o_set_dir_strobe),
    .o_set_dir_value    (o_set_dir_value),
    .o_stop_strobe      (o_stop_strobe),
    .o_start_strobe     (o_start_strobe)
);
